// ===== sv/bbs_pkg.sv =====
// Package for the two-region byte store: sizes, operation and status codes,
// request/result records and controller states. No dependencies.
`timescale 1ns / 1ps

package bbs_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int MAX_REQUEST = 64;
    localparam int CNT_W       = $clog2(MAX_REQUEST + 1);
    localparam int LEN_W       = 11;

    localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(1024);

    typedef logic [2:0] t_op;
    localparam t_op OP_WRITE   = 3'd0;
    localparam t_op OP_PEEK    = 3'd1;
    localparam t_op OP_READ    = 3'd2;
    localparam t_op OP_DISCARD = 3'd3;
    localparam t_op OP_RESET   = 3'd4;

    typedef logic [1:0] t_status;
    localparam t_status STAT_OK       = 2'd0;
    localparam t_status STAT_NO_SPACE = 2'd1;
    localparam t_status STAT_NO_DATA  = 2'd2;
    localparam t_status STAT_INVALID  = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_PEEK
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [LEN_W-1:0] length;
        logic [LEN_W-1:0] offset;
        logic [7:0]       wbyte;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic                has_byte;
        logic [7:0]          read_byte;
        logic                last;
        logic [LEN_W-1:0]    readable;
        logic [LEN_W-1:0]    free_space;
        logic [STORE_AW-1:0] contig_start;
        logic [LEN_W-1:0]    contig_length;
    } t_result;

endpackage

// ===== sv/bbs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// enable and registered read data. No dependencies.
`timescale 1ns / 1ps

module bbs_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/bbs_out_fifo.sv =====
// Two-entry result queue between the controller and the output stream.
// Depends on bbs_pkg.
`timescale 1ns / 1ps

module bbs_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bbs_pkg::t_result i_push_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_ready,
    output bbs_pkg::t_result o_data
);
    import bbs_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/bbs_ctrl.sv =====
// Region bookkeeping, write-run tracking and peek read sequencer of the
// byte store; drives the store RAM ports. Depends on bbs_pkg.
`timescale 1ns / 1ps

module bbs_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bbs_pkg::LEN_W-1:0]    i_cfg_wdata,
    input  logic                         i_req_valid,
    output logic                         o_req_ready,
    input  bbs_pkg::t_req                i_req,
    input  logic                         i_out_full,
    output logic                         o_push,
    output bbs_pkg::t_result             o_push_data,
    output logic                         o_wr_en,
    output logic [bbs_pkg::STORE_AW-1:0] o_wr_addr,
    output logic [7:0]                   o_wr_data,
    output logic                         o_rd_en,
    output logic [bbs_pkg::STORE_AW-1:0] o_rd_addr,
    input  logic [7:0]                   i_rd_data
);
    import bbs_pkg::*;

    // region and write-run state
    logic [LEN_W-1:0]    r_cap,      n_cap_cfg;
    logic [STORE_AW-1:0] r_a_head,   n_a_head;
    logic [LEN_W-1:0]    r_a_size,   n_a_size;
    logic [STORE_AW-1:0] r_b_size,   n_b_size;
    logic                r_wr_active, n_wr_active;
    logic [STORE_AW-1:0] r_wr_addr,  n_wr_addr;
    logic [LEN_W-1:0]    r_wr_left,  n_wr_left;
    logic [LEN_W-1:0]    r_wr_total, n_wr_total;
    logic                r_wr_ok,    n_wr_ok;
    logic                r_wr_wrap,  n_wr_wrap;

    // sequencer and result staging
    t_state              r_state,    n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [STORE_AW-1:0] r_rd_addr;
    logic [LEN_W-1:0]    r_rd_in_a;
    logic                r_rd_pend;
    logic                r_rd_last;
    logic                r_res_pend;
    t_status             r_res_status;

    logic                accept;
    logic                rd_issue;
    logic [LEN_W-1:0]    len;
    logic [LEN_W-1:0]    rd;

    // write placement
    logic [LEN_W-1:0]    sw_addr;
    logic [LEN_W-1:0]    sw_span;
    logic                sw_fit;
    logic                sw_wrap;
    logic                e_ok;
    logic                e_wrap;
    logic [STORE_AW-1:0] e_addr;
    logic [LEN_W-1:0]    e_left;
    logic [LEN_W-1:0]    e_total;
    logic [LEN_W-1:0]    left_nx;

    // discard
    logic [LEN_W-1:0]    dc_from_b;
    logic [LEN_W-1:0]    dc_head_sum;
    logic [STORE_AW-1:0] dc_head;
    logic [LEN_W-1:0]    dc_a;
    logic [STORE_AW-1:0] dc_b;

    // peek
    logic [LEN_W-1:0]    pk_off;
    logic                pk_nodata;
    logic                pk_toolong;
    logic                pk_in_a;
    logic [LEN_W-1:0]    pk_head_sum;
    logic [LEN_W-1:0]    pk_b_pos;
    logic [STORE_AW-1:0] pk_addr;
    logic [LEN_W-1:0]    pk_left_a;
    logic                pk_start;

    logic                do_take;
    logic                set_res;
    t_status             res_status;

    assign accept = i_req_valid && o_req_ready;
    assign len    = i_req.length;
    assign rd     = r_a_size + {1'b0, r_b_size};

    always_comb begin
        n_cap_cfg = i_cfg_wdata;
        if (i_cfg_wdata == '0) begin
            n_cap_cfg = LEN_W'(1);
        end else if (i_cfg_wdata > LEN_W'(STORE_DEPTH)) begin
            n_cap_cfg = LEN_W'(STORE_DEPTH);
        end
    end

    // where a new write goes: after B, after A, or wrapped to address 0
    always_comb begin
        if (r_b_size != '0) begin
            sw_addr = {1'b0, r_b_size};
            sw_span = (r_a_head > r_b_size) ? {1'b0, r_a_head - r_b_size} : '0;
        end else begin
            sw_addr = {1'b0, r_a_head} + r_a_size;
            sw_span = (r_cap > sw_addr) ? r_cap - sw_addr : '0;
        end
        sw_fit  = (len <= sw_span);
        sw_wrap = !sw_fit && (r_b_size == '0) && (len <= {1'b0, r_a_head});
    end

    always_comb begin
        if (r_wr_active) begin
            e_ok    = r_wr_ok;
            e_wrap  = r_wr_wrap;
            e_addr  = r_wr_addr;
            e_left  = r_wr_left;
            e_total = r_wr_total;
        end else begin
            e_ok    = sw_fit || sw_wrap;
            e_wrap  = sw_wrap;
            e_addr  = sw_fit ? sw_addr[STORE_AW-1:0] : '0;
            e_left  = len;
            e_total = len;
        end
        left_nx = e_left - LEN_W'(1);
    end

    always_comb begin
        dc_from_b   = len - r_a_size;
        dc_head_sum = {1'b0, r_a_head} + len;
        dc_head     = r_a_head;
        dc_a        = r_a_size;
        dc_b        = r_b_size;
        if (len == '0) begin
            dc_head = r_a_head;
        end else if (len == rd) begin
            dc_head = '0;
            dc_a    = '0;
            dc_b    = '0;
        end else if (len < r_a_size) begin
            dc_head = dc_head_sum[STORE_AW-1:0];
            dc_a    = r_a_size - len;
        end else begin
            dc_head = dc_from_b[STORE_AW-1:0];
            dc_a    = {1'b0, r_b_size} - dc_from_b;
            dc_b    = '0;
        end
    end

    always_comb begin
        pk_off      = (i_req.op == OP_READ) ? '0 : i_req.offset;
        pk_nodata   = (pk_off > rd) || (len > (rd - pk_off));
        pk_toolong  = (len > LEN_W'(MAX_REQUEST));
        pk_in_a     = (pk_off < r_a_size);
        pk_head_sum = {1'b0, r_a_head} + pk_off;
        pk_b_pos    = pk_off - r_a_size;
        pk_addr     = pk_in_a ? pk_head_sum[STORE_AW-1:0] : pk_b_pos[STORE_AW-1:0];
        pk_left_a   = pk_in_a ? r_a_size - pk_off : '0;
    end

    // request decode
    always_comb begin
        n_a_head    = r_a_head;
        n_a_size    = r_a_size;
        n_b_size    = r_b_size;
        n_wr_active = r_wr_active;
        n_wr_addr   = r_wr_addr;
        n_wr_left   = r_wr_left;
        n_wr_total  = r_wr_total;
        n_wr_ok     = r_wr_ok;
        n_wr_wrap   = r_wr_wrap;
        do_take     = 1'b0;
        set_res     = 1'b0;
        res_status  = STAT_OK;
        pk_start    = 1'b0;
        o_wr_en     = 1'b0;

        if (accept) begin
            if (i_req.op == OP_RESET) begin
                n_a_head    = '0;
                n_a_size    = '0;
                n_b_size    = '0;
                n_wr_active = 1'b0;
                n_wr_addr   = '0;
                n_wr_left   = '0;
                n_wr_total  = '0;
                n_wr_ok     = 1'b0;
                n_wr_wrap   = 1'b0;
                set_res     = 1'b1;
            end else if (r_wr_active) begin
                if (i_req.op == OP_WRITE) begin
                    do_take = 1'b1;
                end else begin
                    set_res    = 1'b1;
                    res_status = STAT_INVALID;
                end
            end else begin
                unique case (i_req.op)
                    OP_WRITE: begin
                        if (len == '0) begin
                            set_res = 1'b1;
                        end else begin
                            do_take = 1'b1;
                        end
                    end
                    OP_DISCARD: begin
                        set_res = 1'b1;
                        if (len > rd) begin
                            res_status = STAT_NO_DATA;
                        end else begin
                            n_a_head = dc_head;
                            n_a_size = dc_a;
                            n_b_size = dc_b;
                        end
                    end
                    OP_PEEK, OP_READ: begin
                        if (pk_nodata) begin
                            set_res    = 1'b1;
                            res_status = STAT_NO_DATA;
                        end else if (pk_toolong) begin
                            set_res    = 1'b1;
                            res_status = STAT_INVALID;
                        end else if (len == '0) begin
                            set_res = 1'b1;
                        end else begin
                            pk_start = 1'b1;
                            if (i_req.op == OP_READ) begin
                                n_a_head = dc_head;
                                n_a_size = dc_a;
                                n_b_size = dc_b;
                            end
                        end
                    end
                    default: begin
                        set_res    = 1'b1;
                        res_status = STAT_INVALID;
                    end
                endcase
            end
        end

        if (do_take) begin
            o_wr_en    = e_ok;
            n_wr_addr  = e_addr + STORE_AW'(1);
            n_wr_ok    = e_ok;
            n_wr_wrap  = e_wrap;
            n_wr_total = e_total;
            n_wr_left  = left_nx;
            if (left_nx == '0) begin
                n_wr_active = 1'b0;
                set_res     = 1'b1;
                res_status  = e_ok ? STAT_OK : STAT_NO_SPACE;
                if (e_ok) begin
                    if (e_wrap) begin
                        n_b_size = e_total[STORE_AW-1:0];
                    end else if (r_b_size != '0) begin
                        n_b_size = r_b_size + e_total[STORE_AW-1:0];
                    end else begin
                        n_a_size = r_a_size + e_total;
                    end
                end
            end else begin
                n_wr_active = 1'b1;
            end
        end
    end

    assign o_wr_addr = e_addr;
    assign o_wr_data = i_req.wbyte;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (pk_start) begin
                    n_state = S_PEEK;
                end
            end
            S_PEEK: begin
                if (rd_issue && (r_cnt == CNT_W'(1))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs; no write is taken while reads are in flight
    always_comb begin
        o_req_ready = (r_state == S_IDLE) && !r_rd_pend && !r_res_pend && !i_out_full;
        rd_issue    = (r_state == S_PEEK) && (!r_rd_pend || !i_out_full);
    end

    assign o_rd_en   = rd_issue;
    assign o_rd_addr = r_rd_addr;

    always_comb begin
        o_push                    = (r_rd_pend || r_res_pend) && !i_out_full;
        o_push_data.status        = r_rd_pend ? STAT_OK : r_res_status;
        o_push_data.has_byte      = r_rd_pend;
        o_push_data.read_byte     = r_rd_pend ? i_rd_data : 8'd0;
        o_push_data.last          = r_rd_pend ? r_rd_last : 1'b1;
        o_push_data.readable      = rd;
        o_push_data.free_space    = (r_cap > rd) ? r_cap - rd : '0;
        o_push_data.contig_start  = (r_a_size != '0) ? r_a_head : '0;
        o_push_data.contig_length = r_a_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_a_head    <= '0;
            r_a_size    <= '0;
            r_b_size    <= '0;
            r_wr_active <= 1'b0;
            r_wr_addr   <= '0;
            r_wr_left   <= '0;
            r_wr_total  <= '0;
            r_wr_ok     <= 1'b0;
            r_wr_wrap   <= 1'b0;
        end else if (i_cfg_we) begin
            r_cap       <= n_cap_cfg;
            r_a_head    <= '0;
            r_a_size    <= '0;
            r_b_size    <= '0;
            r_wr_active <= 1'b0;
            r_wr_addr   <= '0;
            r_wr_left   <= '0;
            r_wr_total  <= '0;
            r_wr_ok     <= 1'b0;
            r_wr_wrap   <= 1'b0;
        end else begin
            r_a_head    <= n_a_head;
            r_a_size    <= n_a_size;
            r_b_size    <= n_b_size;
            r_wr_active <= n_wr_active;
            r_wr_addr   <= n_wr_addr;
            r_wr_left   <= n_wr_left;
            r_wr_total  <= n_wr_total;
            r_wr_ok     <= n_wr_ok;
            r_wr_wrap   <= n_wr_wrap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_rd_pend  <= 1'b0;
            r_res_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pk_start) begin
                r_cnt <= len[CNT_W-1:0];
            end else if (rd_issue) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (rd_issue) begin
                r_rd_pend <= 1'b1;
            end else if (o_push && r_rd_pend) begin
                r_rd_pend <= 1'b0;
            end
            if (set_res) begin
                r_res_pend <= 1'b1;
            end else if (o_push && r_res_pend) begin
                r_res_pend <= 1'b0;
            end
        end
    end

    // read address walks A, then jumps to address 0 for B
    always_ff @(posedge i_clk) begin
        if (pk_start) begin
            r_rd_addr <= pk_addr;
            r_rd_in_a <= pk_left_a;
        end else if (rd_issue) begin
            r_rd_addr <= (r_rd_in_a == LEN_W'(1)) ? '0 : r_rd_addr + STORE_AW'(1);
            r_rd_in_a <= (r_rd_in_a == '0) ? '0 : r_rd_in_a - LEN_W'(1);
        end
        if (rd_issue) begin
            r_rd_last <= (r_cnt == CNT_W'(1));
        end
        if (set_res) begin
            r_res_status <= res_status;
        end
    end

endmodule

// ===== sv/bip_buffer_byte_store.sv =====
// Two-region byte store. Write bytes are taken one per cycle unless the
// result queue is full; a write run's status or single result is registered,
// then queued. Peek/read of N bytes: one per cycle from the single store
// read port unless the queue is full; the next request waits until the last
// byte has left its register. Synchronous active-low reset empties the
// regions and sets capacity to 1024; store contents are not cleared.
`timescale 1ns / 1ps

module bip_buffer_byte_store (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // length[10:0], offset[21:11], write_byte[29:22], zero[31:30]
    input  logic [31:0] s_axis_tdata,
    // operation[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], read_byte[9:2], readable[20:10], free_space[31:21],
    // contiguous_start[41:32], contiguous_length[52:42], zero[55:53]
    output logic [55:0] m_axis_tdata,
    // has_byte[0]
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import bbs_pkg::*;

    t_req                req;
    t_result             push_data;
    t_result             out_data;
    logic                push;
    logic                out_full;
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
    logic [7:0]          rd_data;

    always_comb begin
        req.op     = s_axis_tuser;
        req.length = s_axis_tdata[10:0];
        req.offset = s_axis_tdata[21:11];
        req.wbyte  = s_axis_tdata[29:22];
    end

    bbs_ram #(
        .DEPTH(STORE_DEPTH),
        .WIDTH(8)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .i_out_full  (out_full),
        .o_push      (push),
        .o_push_data (push_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    bbs_out_fifo u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (out_full),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (out_data)
    );

    assign m_axis_tdata = {3'b000,
                           out_data.contig_length,
                           out_data.contig_start,
                           out_data.free_space,
                           out_data.readable,
                           out_data.read_byte,
                           out_data.status};
    assign m_axis_tuser = out_data.has_byte;
    assign m_axis_tlast = out_data.last;

endmodule

// ===== sv/bbs_checker.sv =====
// Port-level checks for the byte store result stream, bound to the top
// level. Depends on the ports of bip_buffer_byte_store.
`timescale 1ns / 1ps

module bbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a result without a byte always ends its request
    a_nobyte_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata[9:2] == 8'd0))
        else $error("byteless result not last or byte nonzero");

    // error status never carries a byte
    a_err_nobyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != 2'd0) |-> !m_axis_tuser[0])
        else $error("error result carries a byte");

    // region A never exceeds the readable total
    a_span_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[52:42] <= m_axis_tdata[20:10]))
        else $error("contiguous span exceeds readable bytes");

endmodule

bind bip_buffer_byte_store bbs_checker u_bbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
